FILE: rtl/bmpd_pkg.sv
// Shared constants for the BMP stream decoder: result kinds, fault codes,
// header field offsets and the fixed field widths. No dependencies.
package bmpd_pkg;

  localparam int PIX_VAL_W = 32;
  localparam int PIX_IDX_W = 24;
  localparam int DIM_OUT_W = 13;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] FAULT_NONE        = 3'd0;
  localparam logic [2:0] FAULT_INVALID     = 3'd1;
  localparam logic [2:0] FAULT_COMPRESSED  = 3'd2;
  localparam logic [2:0] FAULT_PALETTE     = 3'd3;
  localparam logic [2:0] FAULT_TRUNCATED   = 3'd4;
  localparam logic [2:0] FAULT_UNSUPPORTED = 3'd5;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] INFO_HDR_SIZE = 32'h28;
  localparam logic [15:0] DEPTH_24      = 16'd24;
  localparam logic [15:0] DEPTH_32      = 16'd32;

  // Byte offsets of the header fields that are checked or used.
  localparam logic [5:0] OFF_SIG      = 6'd0;
  localparam logic [5:0] OFF_RSV      = 6'd6;
  localparam logic [5:0] OFF_HSIZE    = 6'd14;
  localparam logic [5:0] OFF_WIDTH    = 6'd18;
  localparam logic [5:0] OFF_HEIGHT   = 6'd22;
  localparam logic [5:0] OFF_PLANES   = 6'd26;
  localparam logic [5:0] OFF_BITS     = 6'd28;
  localparam logic [5:0] OFF_COMP     = 6'd30;
  localparam logic [5:0] OFF_PALETTE  = 6'd46;

  // Count of header bytes already taken when the closing byte of each header arrives.
  localparam logic [5:0] FILE_HDR_LAST = 6'd13;
  localparam logic [5:0] HDR_LAST      = 6'd53;

endpackage

FILE: rtl/bmpd_ifs.sv
// Valid/ready channel interfaces of the BMP stream decoder: byte input and
// result output. Depends on bmpd_pkg for the payload widths.
interface bmpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source (output valid, output data_byte, output end_marker, input ready);
  modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

interface bmpd_out_if import bmpd_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_kind;
  logic [PIX_VAL_W-1:0] pixel_value;
  logic [PIX_IDX_W-1:0] pixel_index;
  logic                 last_pixel;
  logic [DIM_OUT_W-1:0] image_width;
  logic [DIM_OUT_W-1:0] image_height;
  logic                 has_alpha;
  logic [2:0]           fault_code;

  modport source (output valid, output result_kind, output pixel_value, output pixel_index,
                  output last_pixel, output image_width, output image_height,
                  output has_alpha, output fault_code, input ready);
  modport sink   (input valid, input result_kind, input pixel_value, input pixel_index,
                  input last_pixel, input image_width, input image_height,
                  input has_alpha, input fault_code, output ready);
endinterface

FILE: rtl/bmp_stream_decoder_core.sv
// Top level of the BMP stream decoder: header capture and checks, pixel
// assembly and the result register. Depends on bmpd_pkg and bmpd_ifs.

// The decoder takes one file byte per cycle and gives at most one result per byte,
// in the cycle after the byte is accepted; a word with end_marker set closes the file.
// It takes a new word in every cycle as long as the result register is free or is
// being read in the same cycle, so a stalled output stops the input only when a
// result is waiting. The file header is checked on its 14th byte and the info
// header on the 54th; then come one header result and one pixel result per 3
// (24-bit, bottom-up rows flipped, row padding dropped) or 4 (32-bit) bytes.
// Errors end the image; bytes are then ignored until the next end_marker.
module bmp_stream_decoder_core import bmpd_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  bmpd_in_if.sink         in_ch,
  bmpd_out_if.source      out_ch
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PIXELS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Captured header fields.
  logic [15:0] sig_r;
  logic [31:0] rsv_r;
  logic [31:0] hsize_r;
  logic [31:0] width_r;
  logic [31:0] height_r;
  logic [15:0] planes_r;
  logic [15:0] bits_r;
  logic [31:0] comp_r;
  logic [31:0] pal_r;
  logic [PIX_IDX_W-1:0] flip_base_r;

  logic [1:0]           phase_r, phase_nxt;
  logic [5:0]           hcnt_r, hcnt_nxt;
  logic [DIM_W-1:0]     col_r, col_nxt;
  logic [DIM_W-1:0]     row_r, row_nxt;
  logic [1:0]           bip_r, bip_nxt;
  logic [1:0]           pad_r, pad_nxt;
  logic [2:0][7:0]      accum_r;
  logic [PIX_IDX_W-1:0] rbi_r, rbi_nxt;

  logic                 out_valid_r;
  logic [1:0]           out_kind_r;
  logic [PIX_VAL_W-1:0] out_val_r;
  logic [PIX_IDX_W-1:0] out_idx_r;
  logic                 out_last_r;
  logic [DIM_OUT_W-1:0] out_w_r;
  logic [DIM_OUT_W-1:0] out_h_r;
  logic                 out_alpha_r;
  logic [2:0]           out_fault_r;

  logic                 in_fire;
  logic                 byte_fire;
  logic                 alpha;
  logic [1:0]           need;
  logic [DIM_W-1:0]     w_d, h_d;
  logic [DIM_W-1:0]     col_inc, row_inc;
  logic [2:0]           file_fault;
  logic [2:0]           info_fault;
  logic                 acc_we;

  logic                 res_valid;
  logic [1:0]           res_kind;
  logic [PIX_VAL_W-1:0] res_val;
  logic [PIX_IDX_W-1:0] res_idx;
  logic                 res_last;
  logic [2:0]           res_fault;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign byte_fire   = in_fire && !in_ch.end_marker;

  assign alpha   = (bits_r == DEPTH_32);
  assign need    = alpha ? 2'd3 : 2'd2;
  assign w_d     = width_r[DIM_W-1:0];
  assign h_d     = height_r[DIM_W-1:0];
  assign col_inc = col_r + 1'b1;
  assign row_inc = row_r + 1'b1;

  always_comb begin
    if (sig_r != BMP_SIGNATURE || rsv_r != '0) begin
      file_fault = FAULT_INVALID;
    end else begin
      file_fault = FAULT_NONE;
    end
  end

  always_comb begin
    if (hsize_r != INFO_HDR_SIZE) begin
      info_fault = FAULT_INVALID;
    end else if (width_r == '0 || width_r[31]) begin
      info_fault = FAULT_INVALID;
    end else if (height_r == '0 || height_r[31]) begin
      info_fault = FAULT_INVALID;
    end else if (planes_r != 16'd1) begin
      info_fault = FAULT_INVALID;
    end else if (bits_r == '0 || comp_r != '0) begin
      info_fault = FAULT_COMPRESSED;
    end else if (width_r > 32'(MAX_DIM) || height_r > 32'(MAX_DIM)) begin
      info_fault = FAULT_INVALID;
    end else if (bits_r == DEPTH_24 || bits_r == DEPTH_32) begin
      info_fault = (pal_r != '0) ? FAULT_PALETTE : FAULT_NONE;
    end else if (bits_r == 16'd1 || bits_r == 16'd4 || bits_r == 16'd8 ||
                 bits_r == 16'd16) begin
      info_fault = FAULT_UNSUPPORTED;
    end else begin
      info_fault = FAULT_INVALID;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    bip_nxt   = bip_r;
    pad_nxt   = pad_r;
    rbi_nxt   = rbi_r;
    acc_we    = 1'b0;
    res_valid = 1'b0;
    res_kind  = KIND_PIXEL;
    res_val   = '0;
    res_idx   = '0;
    res_last  = 1'b0;
    res_fault = FAULT_NONE;
    if (in_fire) begin
      if (in_ch.end_marker) begin
        phase_nxt = PH_HEADER;
        hcnt_nxt  = '0;
        col_nxt   = '0;
        row_nxt   = '0;
        bip_nxt   = '0;
        pad_nxt   = '0;
        rbi_nxt   = '0;
        if (phase_r != PH_DONE) begin
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_fault = FAULT_TRUNCATED;
        end
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            hcnt_nxt = hcnt_r + 1'b1;
            if (hcnt_r == FILE_HDR_LAST && file_fault != FAULT_NONE) begin
              phase_nxt = PH_DONE;
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              res_fault = file_fault;
            end else if (hcnt_r == HDR_LAST) begin
              res_valid = 1'b1;
              if (info_fault != FAULT_NONE) begin
                phase_nxt = PH_DONE;
                res_kind  = KIND_ERROR;
                res_fault = info_fault;
              end else begin
                phase_nxt = PH_PIXELS;
                res_kind  = KIND_HEADER;
                col_nxt   = '0;
                row_nxt   = '0;
                bip_nxt   = '0;
                pad_nxt   = '0;
                // 24-bit rows are stored bottom-up, so the first row lands last.
                rbi_nxt   = alpha ? '0 : flip_base_r;
              end
            end
          end
          PH_PIXELS: begin
            if (pad_r != '0) begin
              pad_nxt = pad_r - 1'b1;
              if (pad_r == 2'd1 && row_r >= h_d) begin
                phase_nxt = PH_DONE;
              end
            end else if (bip_r < need) begin
              acc_we  = 1'b1;
              bip_nxt = bip_r + 1'b1;
            end else begin
              res_valid = 1'b1;
              res_kind  = KIND_PIXEL;
              res_val   = alpha ? {in_ch.data_byte, accum_r[2], accum_r[1], accum_r[0]}
                                : {8'h00, in_ch.data_byte, accum_r[1], accum_r[0]};
              res_idx   = rbi_r + {{(PIX_IDX_W-DIM_W){1'b0}}, col_r};
              res_last  = (row_inc == h_d) && (col_inc == w_d);
              bip_nxt   = '0;
              if (col_inc >= w_d) begin
                col_nxt = '0;
                row_nxt = row_inc;
                rbi_nxt = alpha ? rbi_r + width_r[PIX_IDX_W-1:0]
                                : rbi_r - width_r[PIX_IDX_W-1:0];
                // Rows of 3-byte pixels pad out by width mod 4 bytes.
                pad_nxt = alpha ? 2'd0 : width_r[1:0];
                if ((alpha || width_r[1:0] == 2'd0) && row_inc >= h_d) begin
                  phase_nxt = PH_DONE;
                end
              end else begin
                col_nxt = col_inc;
              end
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      bip_r   <= '0;
      pad_r   <= '0;
      rbi_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      bip_r   <= bip_nxt;
      pad_r   <= pad_nxt;
      rbi_r   <= rbi_nxt;
    end
  end

  // Header byte capture into the fields that are checked later.
  always_ff @(posedge clk) begin
    if (byte_fire && phase_r == PH_HEADER) begin
      unique case (hcnt_r)
        OFF_SIG:          sig_r[7:0]      <= in_ch.data_byte;
        OFF_SIG + 6'd1:   sig_r[15:8]     <= in_ch.data_byte;
        OFF_RSV:          rsv_r[7:0]      <= in_ch.data_byte;
        OFF_RSV + 6'd1:   rsv_r[15:8]     <= in_ch.data_byte;
        OFF_RSV + 6'd2:   rsv_r[23:16]    <= in_ch.data_byte;
        OFF_RSV + 6'd3:   rsv_r[31:24]    <= in_ch.data_byte;
        OFF_HSIZE:        hsize_r[7:0]    <= in_ch.data_byte;
        OFF_HSIZE + 6'd1: hsize_r[15:8]   <= in_ch.data_byte;
        OFF_HSIZE + 6'd2: hsize_r[23:16]  <= in_ch.data_byte;
        OFF_HSIZE + 6'd3: hsize_r[31:24]  <= in_ch.data_byte;
        OFF_WIDTH:        width_r[7:0]    <= in_ch.data_byte;
        OFF_WIDTH + 6'd1: width_r[15:8]   <= in_ch.data_byte;
        OFF_WIDTH + 6'd2: width_r[23:16]  <= in_ch.data_byte;
        OFF_WIDTH + 6'd3: width_r[31:24]  <= in_ch.data_byte;
        OFF_HEIGHT:        height_r[7:0]   <= in_ch.data_byte;
        OFF_HEIGHT + 6'd1: height_r[15:8]  <= in_ch.data_byte;
        OFF_HEIGHT + 6'd2: height_r[23:16] <= in_ch.data_byte;
        OFF_HEIGHT + 6'd3: height_r[31:24] <= in_ch.data_byte;
        OFF_PLANES:        planes_r[7:0]   <= in_ch.data_byte;
        OFF_PLANES + 6'd1: planes_r[15:8]  <= in_ch.data_byte;
        OFF_BITS:          bits_r[7:0]     <= in_ch.data_byte;
        OFF_BITS + 6'd1:   bits_r[15:8]    <= in_ch.data_byte;
        OFF_COMP:          comp_r[7:0]     <= in_ch.data_byte;
        OFF_COMP + 6'd1:   comp_r[15:8]    <= in_ch.data_byte;
        OFF_COMP + 6'd2:   comp_r[23:16]   <= in_ch.data_byte;
        OFF_COMP + 6'd3:   comp_r[31:24]   <= in_ch.data_byte;
        OFF_PALETTE:        pal_r[7:0]     <= in_ch.data_byte;
        OFF_PALETTE + 6'd1: pal_r[15:8]    <= in_ch.data_byte;
        OFF_PALETTE + 6'd2: pal_r[23:16]   <= in_ch.data_byte;
        OFF_PALETTE + 6'd3: pal_r[31:24]   <= in_ch.data_byte;
        default: begin
        end
      endcase
    end
  end

  // Start index of the bottom row; width and height are settled long before
  // the info header's last byte, so the registered product is ready in time.
  always_ff @(posedge clk) begin
    flip_base_r <= PIX_IDX_W'((height_r[PIX_IDX_W-1:0] - 1'b1) * width_r[PIX_IDX_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      accum_r[bip_r] <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_kind_r  <= res_kind;
      out_val_r   <= res_val;
      out_idx_r   <= res_idx;
      out_last_r  <= res_last;
      out_fault_r <= res_fault;
      if (res_kind == KIND_ERROR) begin
        out_w_r     <= '0;
        out_h_r     <= '0;
        out_alpha_r <= 1'b0;
      end else begin
        out_w_r     <= width_r[DIM_OUT_W-1:0];
        out_h_r     <= height_r[DIM_OUT_W-1:0];
        out_alpha_r <= alpha;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.pixel_value  = out_val_r;
  assign out_ch.pixel_index  = out_idx_r;
  assign out_ch.last_pixel   = out_last_r;
  assign out_ch.image_width  = out_w_r;
  assign out_ch.image_height = out_h_r;
  assign out_ch.has_alpha    = out_alpha_r;
  assign out_ch.fault_code   = out_fault_r;

  a_error_has_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_ERROR) |-> (out_fault_r != FAULT_NONE))
    else $error("error word without a fault code");

  a_ok_has_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_ERROR) |-> (out_fault_r == FAULT_NONE))
    else $error("header or pixel word carries a fault code");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == KIND_PIXEL))
    else $error("last pixel flag on a non-pixel word");

  a_hcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (hcnt_r <= HDR_LAST))
    else $error("header byte count ran past the header");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.end_marker) |=> (phase_r == PH_HEADER && hcnt_r == '0))
    else $error("end marker did not restart the parser");

endmodule

FILE: bench/bmp_stream_decoder_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for bmp_stream_decoder_core: feeds whole and broken BMP files as bytes,
// predicts every header, pixel and error result and checks them. Needs bmpd_pkg and bmpd_ifs.
module bmp_stream_decoder_core_tb;
  import bmpd_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam int FILE_HDR_LEN = 14;
  localparam int HDR_LEN = 54;
  localparam int NO_CUT = -1;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTED = 40;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  typedef enum logic [1:0] {STAGE_HEADER, STAGE_PIXELS, STAGE_DONE} stage_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_marker;
  } word_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [PIX_VAL_W-1:0] value;
    logic [PIX_IDX_W-1:0] index;
    logic                 last;
    logic [DIM_OUT_W-1:0] width;
    logic [DIM_OUT_W-1:0] height;
    logic                 alpha;
    logic [2:0]           fault;
  } result_t;

  typedef struct packed {
    logic [15:0] sig;
    logic [31:0] reserved;
    logic [31:0] info_size;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] planes;
    logic [15:0] bits;
    logic [31:0] comp;
    logic [31:0] palette;
  } hdr_fields_t;

  logic clk = 1'b0;
  logic rst_n;

  bmpd_in_if  word_ch ();
  bmpd_out_if result_ch ();

  bmp_stream_decoder_core #(.MAX_DIM(MAX_DIM)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (word_ch),
    .out_ch (result_ch)
  );

  always #5 clk = ~clk;

  word_t       file_words[$];
  result_t     predicted_results[$];
  int unsigned words_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        rx_hold;

  // Decoder state as the bench sees it.
  logic [7:0]  hdr_bytes [0:HDR_LEN-1];
  stage_t      stage = STAGE_HEADER;
  logic [31:0] hdr_taken = '0;
  logic [31:0] col_pos = '0;
  logic [31:0] row_pos = '0;
  logic [31:0] chan_pos = '0;
  logic [31:0] pad_left = '0;
  logic [31:0] pix_acc = '0;
  logic [31:0] row_base = '0;

  function automatic logic [31:0] field16(input int off);
    return {16'h0, hdr_bytes[off + 1], hdr_bytes[off]};
  endfunction

  function automatic logic [31:0] field32(input int off);
    return {hdr_bytes[off + 3], hdr_bytes[off + 2], hdr_bytes[off + 1], hdr_bytes[off]};
  endfunction

  function automatic logic [2:0] file_header_fault();
    if (field16(OFF_SIG) != BMP_SIGNATURE) return FAULT_INVALID;
    if (field16(OFF_RSV) != 0 || field16(OFF_RSV + 2) != 0) return FAULT_INVALID;
    return FAULT_NONE;
  endfunction

  function automatic logic [2:0] info_header_fault();
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] bits;
    w = field32(OFF_WIDTH);
    h = field32(OFF_HEIGHT);
    bits = field16(OFF_BITS);
    if (field32(OFF_HSIZE) != INFO_HDR_SIZE) return FAULT_INVALID;
    if (w == 0 || w[31]) return FAULT_INVALID;
    if (h == 0 || h[31]) return FAULT_INVALID;
    if (field16(OFF_PLANES) != 1) return FAULT_INVALID;
    if (bits == 0) return FAULT_COMPRESSED;
    if (field32(OFF_COMP) != 0) return FAULT_COMPRESSED;
    if (w > MAX_DIM || h > MAX_DIM) return FAULT_INVALID;
    if (bits == DEPTH_24 || bits == DEPTH_32) begin
      return (field32(OFF_PALETTE) != 0) ? FAULT_PALETTE : FAULT_NONE;
    end
    if (bits == 1 || bits == 4 || bits == 8 || bits == 16) return FAULT_UNSUPPORTED;
    return FAULT_INVALID;
  endfunction

  task automatic expect_result(input logic [1:0] kind, input logic [31:0] value,
                               input logic [31:0] index, input logic last,
                               input logic [2:0] fault);
    result_t     r;
    logic [31:0] w;
    logic [31:0] h;
    w = field32(OFF_WIDTH);
    h = field32(OFF_HEIGHT);
    r.kind = kind;
    r.value = value;
    r.index = index[PIX_IDX_W-1:0];
    r.last = last;
    r.fault = fault;
    if (kind == KIND_ERROR) begin
      r.width = '0;
      r.height = '0;
      r.alpha = 1'b0;
    end else begin
      r.width = w[DIM_OUT_W-1:0];
      r.height = h[DIM_OUT_W-1:0];
      r.alpha = field16(OFF_BITS) == DEPTH_32;
    end
    predicted_results.push_back(r);
  endtask

  // Advances the bench's copy of the decoder by one accepted word.
  task automatic decode_word(input word_t wd);
    logic [2:0]  fault;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] pix;
    logic        alpha;
    logic        last;
    w = field32(OFF_WIDTH);
    h = field32(OFF_HEIGHT);
    alpha = field16(OFF_BITS) == DEPTH_32;
    if (wd.end_marker) begin
      if (stage != STAGE_DONE) expect_result(KIND_ERROR, 0, 0, 1'b0, FAULT_TRUNCATED);
      stage = STAGE_HEADER;
      hdr_taken = 0;
      col_pos = 0;
      row_pos = 0;
      chan_pos = 0;
      pad_left = 0;
      pix_acc = 0;
      row_base = 0;
    end else if (stage == STAGE_HEADER) begin
      hdr_bytes[hdr_taken] = wd.data_byte;
      hdr_taken++;
      if (hdr_taken == FILE_HDR_LEN) begin
        fault = file_header_fault();
        if (fault != FAULT_NONE) begin
          stage = STAGE_DONE;
          expect_result(KIND_ERROR, 0, 0, 1'b0, fault);
        end
      end else if (hdr_taken == HDR_LEN) begin
        fault = info_header_fault();
        if (fault != FAULT_NONE) begin
          stage = STAGE_DONE;
          expect_result(KIND_ERROR, 0, 0, 1'b0, fault);
        end else begin
          w = field32(OFF_WIDTH);
          h = field32(OFF_HEIGHT);
          stage = STAGE_PIXELS;
          // 24-bit rows are stored bottom-up, so the first row lands at the bottom.
          row_base = (field16(OFF_BITS) == DEPTH_32) ? 32'd0 : (h - 1) * w;
          expect_result(KIND_HEADER, 0, 0, 1'b0, FAULT_NONE);
        end
      end
    end else if (stage == STAGE_PIXELS) begin
      if (pad_left != 0) begin
        pad_left--;
        if (pad_left == 0 && row_pos >= h) stage = STAGE_DONE;
      end else if (chan_pos < (alpha ? 3 : 2)) begin
        pix_acc = pix_acc | (32'(wd.data_byte) << (8 * chan_pos));
        chan_pos++;
      end else begin
        pix = alpha ? (pix_acc | (32'(wd.data_byte) << 24))
                    : (pix_acc | (32'(wd.data_byte) << 16));
        last = (row_pos + 1 == h) && (col_pos + 1 == w);
        expect_result(KIND_PIXEL, pix, row_base + col_pos, last, FAULT_NONE);
        pix_acc = 0;
        chan_pos = 0;
        col_pos++;
        if (col_pos >= w) begin
          col_pos = 0;
          row_pos++;
          row_base = alpha ? row_base + w : row_base - w;
          pad_left = alpha ? 32'd0 : (w & 32'd3);
          if (pad_left == 0 && row_pos >= h) stage = STAGE_DONE;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (predicted_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
    end else begin
      want = predicted_results.pop_front();
      check_field("result_kind", result_ch.result_kind, want.kind);
      check_field("pixel_value", result_ch.pixel_value, want.value);
      check_field("pixel_index", result_ch.pixel_index, want.index);
      check_field("last_pixel", result_ch.last_pixel, want.last);
      check_field("image_width", result_ch.image_width, want.width);
      check_field("image_height", result_ch.image_height, want.height);
      check_field("has_alpha", result_ch.has_alpha, want.alpha);
      check_field("fault_code", result_ch.fault_code, want.fault);
    end
  endtask

  always @(posedge clk) begin : word_driver
    logic accepted;
    logic offer;
    if (!rst_n) begin
      word_ch.valid <= 1'b0;
    end else begin
      accepted = word_ch.valid && word_ch.ready;
      if (accepted) decode_word(file_words.pop_front());
      if (word_ch.valid && !accepted) begin
        offer = 1'b1;
      end else begin
        offer = (file_words.size() != 0) && ($urandom_range(99) >= tx_idle_pct);
      end
      word_ch.valid <= offer;
      if (offer) begin
        word_ch.data_byte <= file_words[0].data_byte;
        word_ch.end_marker <= file_words[0].end_marker;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) check_result();
      result_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // One long stall of the result side so that the decoder backs up into its input.
  initial begin : rx_holdoff
    rx_hold = 1'b0;
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  task automatic queue_word(input logic [7:0] b, input logic eom);
    word_t wd;
    wd.data_byte = b;
    wd.end_marker = eom;
    file_words.push_back(wd);
    words_queued++;
  endtask

  function automatic hdr_fields_t good_fields(input logic [31:0] w, input logic [31:0] h,
                                              input logic [15:0] bits);
    hdr_fields_t f;
    f.sig = BMP_SIGNATURE;
    f.reserved = '0;
    f.info_size = INFO_HDR_SIZE;
    f.width = w;
    f.height = h;
    f.planes = 16'd1;
    f.bits = bits;
    f.comp = '0;
    f.palette = '0;
    return f;
  endfunction

  function automatic int unsigned pixel_bytes(input int unsigned w, input int unsigned h,
                                              input logic [15:0] bits);
    return (bits == DEPTH_32) ? 4 * w * h : h * (3 * w + (w % 4));
  endfunction

  // Fields not checked by the decoder (file size, data offset and so on) are left random.
  task automatic queue_header(input hdr_fields_t f, input int unsigned keep);
    logic [8*HDR_LEN-1:0] hdr;
    for (int i = 0; i < HDR_LEN; i++) hdr[8*i +: 8] = 8'($urandom_range(255));
    hdr[8*OFF_SIG +: 16] = f.sig;
    hdr[8*OFF_RSV +: 32] = f.reserved;
    hdr[8*OFF_HSIZE +: 32] = f.info_size;
    hdr[8*OFF_WIDTH +: 32] = f.width;
    hdr[8*OFF_HEIGHT +: 32] = f.height;
    hdr[8*OFF_PLANES +: 16] = f.planes;
    hdr[8*OFF_BITS +: 16] = f.bits;
    hdr[8*OFF_COMP +: 32] = f.comp;
    hdr[8*OFF_PALETTE +: 32] = f.palette;
    for (int i = 0; i < keep; i++) queue_word(hdr[8*i +: 8], 1'b0);
  endtask

  task automatic queue_rejected(input hdr_fields_t f);
    queue_header(f, HDR_LEN);
    repeat ($urandom_range(0, 6)) queue_word(8'($urandom_range(255)), 1'b0);
    queue_word(8'($urandom_range(255)), 1'b1);
  endtask

  // cut < 0 sends the whole image plus trailing bytes, else only cut pixel bytes.
  task automatic queue_image(input int unsigned w, input int unsigned h,
                             input logic [15:0] bits, input int unsigned trail, input int cut);
    int unsigned stop;
    queue_header(good_fields(w, h, bits), HDR_LEN);
    stop = (cut < 0) ? pixel_bytes(w, h, bits) + trail : cut;
    for (int unsigned i = 0; i < stop; i++) queue_word(8'($urandom_range(255)), 1'b0);
    queue_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic queue_broken_file();
    hdr_fields_t f;
    f = good_fields($urandom_range(1, 8), $urandom_range(1, 8),
                    $urandom_range(1) ? DEPTH_32 : DEPTH_24);
    case ($urandom_range(11))
      0: f.sig = 16'($urandom_range(16'hFFFF));
      1: f.reserved = 32'h1 << $urandom_range(31);
      2: f.info_size = $urandom;
      3: f.width = $urandom_range(1) ? 32'd0 : ($urandom | 32'h8000_0000);
      4: f.height = $urandom_range(1) ? 32'd0 : ($urandom | 32'h8000_0000);
      5: f.planes = 16'($urandom_range(16'hFFFF));
      6: f.bits = 16'($urandom_range(40));
      7: f.comp = $urandom_range(1, 6);
      8: begin
        if ($urandom_range(1)) f.width = $urandom_range(MAX_DIM + 1, 65535);
        else f.height = $urandom_range(MAX_DIM + 1, 65535);
      end
      9: f.palette = $urandom_range(1, 256);
      10: begin
        f.info_size = $urandom;
        f.width = $urandom;
        f.height = $urandom;
        f.planes = 16'($urandom);
        f.bits = 16'($urandom);
        f.comp = $urandom;
        f.palette = $urandom;
      end
      default: begin
        // File stops in the middle of the headers.
        queue_header(f, $urandom_range(1, HDR_LEN - 1));
        queue_word(8'($urandom_range(255)), 1'b1);
        return;
      end
    endcase
    queue_rejected(f);
  endtask

  task automatic queue_random_files(input int unsigned word_goal);
    int unsigned start;
    int unsigned w;
    int unsigned h;
    logic [15:0] bits;
    start = words_queued;
    while (words_queued - start < word_goal) begin
      if ($urandom_range(99) < 4) begin
        queue_word(8'($urandom_range(255)), 1'b1);
      end else if ($urandom_range(99) < 68) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        bits = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
        if ($urandom_range(9) == 0) begin
          queue_image(w, h, bits, 0, $urandom_range(0, pixel_bytes(w, h, bits) - 1));
        end else begin
          queue_image(w, h, bits, $urandom_range(0, 3), NO_CUT);
        end
      end else begin
        queue_broken_file();
      end
    end
  endtask

  task automatic wait_drained();
    while (file_words.size() != 0 || word_ch.valid || predicted_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    queue_random_files(100);
    wait_drained();
  endtask

  initial begin : stimulus
    hdr_fields_t f;
    rst_n = 1'b0;
    word_ch.valid = 1'b0;
    word_ch.data_byte = 8'h00;
    word_ch.end_marker = 1'b0;
    result_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Empty files, back to back.
    queue_word(8'h00, 1'b1);
    queue_word(8'hFF, 1'b1);
    // File header faults are flagged on its last byte.
    f = good_fields(2, 2, DEPTH_24); f.sig = 16'h424D;              queue_rejected(f);
    f = good_fields(2, 2, DEPTH_24); f.reserved = 32'h0000_0001;    queue_rejected(f);
    f = good_fields(2, 2, DEPTH_24); f.reserved = 32'h8000_0000;    queue_rejected(f);
    // Info header checks in their order of priority.
    f = good_fields(2, 2, DEPTH_24); f.info_size = 32'd12;          queue_rejected(f);
    f = good_fields(0, 2, DEPTH_24);                                queue_rejected(f);
    f = good_fields(32'hFFFF_FFFF, 2, DEPTH_24);                    queue_rejected(f);
    f = good_fields(2, 0, DEPTH_24);                                queue_rejected(f);
    f = good_fields(2, 32'h8000_0000, DEPTH_32);                    queue_rejected(f);
    f = good_fields(2, 2, DEPTH_24); f.planes = 16'd0;              queue_rejected(f);
    f = good_fields(2, 2, 16'd0);                                   queue_rejected(f);
    f = good_fields(2, 2, 16'd8); f.comp = 32'd1;                   queue_rejected(f);
    f = good_fields(MAX_DIM + 1, 2, DEPTH_24);                      queue_rejected(f);
    f = good_fields(2, 32'h0001_0000, DEPTH_32);                    queue_rejected(f);
    f = good_fields(2, 2, DEPTH_24); f.palette = 32'd1;             queue_rejected(f);
    f = good_fields(2, 2, DEPTH_32); f.palette = 32'd256;           queue_rejected(f);
    queue_rejected(good_fields(2, 2, 16'd1));
    queue_rejected(good_fields(2, 2, 16'd4));
    queue_rejected(good_fields(2, 2, 16'd8));
    queue_rejected(good_fields(2, 2, 16'd16));
    queue_rejected(good_fields(2, 2, 16'd7));
    // Truncation inside the headers, before and after the file header check.
    queue_header(good_fields(2, 2, DEPTH_24), FILE_HDR_LEN - 1);
    queue_word(8'h00, 1'b1);
    queue_header(good_fields(2, 2, DEPTH_24), FILE_HDR_LEN);
    queue_word(8'hFF, 1'b1);
    // Complete images, every row padding, trailing bytes after the data.
    queue_image(1, 1, DEPTH_24, 0, NO_CUT);
    queue_image(1, 1, DEPTH_32, 0, NO_CUT);
    for (int unsigned w = 1; w <= 4; w++) queue_image(w, 2, DEPTH_24, 3, NO_CUT);
    queue_image(3, 2, DEPTH_32, 2, NO_CUT);
    // Truncation in the pixels and inside the padding after the last pixel.
    queue_image(5, 3, DEPTH_32, 0, 17);
    queue_image(3, 2, DEPTH_24, 0, pixel_bytes(3, 2, DEPTH_24) - 1);
    // Largest images: only the first pixels, then an early end.
    queue_image(MAX_DIM, MAX_DIM, DEPTH_24, 0, 9);
    queue_image(MAX_DIM, MAX_DIM, DEPTH_32, 0, 12);
    wait_drained();

    hold_req = 1'b1;
    queue_image(8, 4, DEPTH_32, 0, NO_CUT);
    wait_drained();

    run_phase(0, 0);
    run_phase(59, 0);
    run_phase(0, 59);
    run_phase(38, 38);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                predicted_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
